// File: hw/rtl/sll_pkg.sv
// sll_pkg: token kinds, error codes, result word type and character classes
// for the lexer. No dependencies; imported by simple_language_lexer.
`default_nettype none

package sll_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [3:0] {
    KIND_NAME   = 4'd0,
    KIND_INT    = 4'd1,
    KIND_LPAREN = 4'd2,
    KIND_RPAREN = 4'd3,
    KIND_LBRACE = 4'd4,
    KIND_RBRACE = 4'd5,
    KIND_SEMI   = 4'd6,
    KIND_ASSIGN = 4'd7,
    KIND_ARITH  = 4'd8,
    KIND_COND   = 4'd9,
    KIND_REL    = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_LONE_OP    = 2'd2,
    ERR_END_OP     = 2'd3
  } err_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One result word as queued for the output.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       first;
    logic       last;
    err_t       err;
    logic       run_last;
  } res_t;

  function automatic res_t mk_res(kind_t kind, logic [7:0] ch, logic first,
                                  logic last, err_t err);
    res_t r;
    r.kind     = kind;
    r.ch       = ch;
    r.first    = first;
    r.last     = last;
    r.err      = err;
    r.run_last = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/simple_language_lexer.sv
// simple_language_lexer: one-character-lookahead lexer, stream in and out.
// Uses sll_pkg. Result words pass through a registered queue before out_*.
// Throughput: one input word per cycle while the queue has room; a byte yielding two
// result words takes two output transfers; a run of such bytes halves the input rate.
// Reset (rst_n low, synchronous) clears the lookahead, the error halt and the queue.
`default_nettype none

module simple_language_lexer
  import sll_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // end_marker
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] char_out, [8] token_first,
                                       // [9] token_last, [11:10] error_code,
                                       // [15:12] zero
  output logic [3:0]       out_tuser,  // [3:0] token_kind
  output logic             out_tlast   // run_last
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // Lookahead state: the held character still waiting for its follower.
  logic [7:0]  held_char_r,  held_char_nxt;
  kind_t       held_kind_r,  held_kind_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        held_first_r, held_first_nxt;
  logic        halt_r,       halt_nxt;

  // Result queue
  res_t             q_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic [1:0] n_res;
  res_t       r0, r1, br;
  logic       used, bemit;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;
  assign c       = in_tdata;

  // Room for the worst case of two words per byte.
  assign in_tready = cnt_r <= CNT_W'(FIFO_DEPTH - 2);

  // Lexing step: resolve the held character against this byte, then start
  // a new token with the byte if the resolution did not swallow it.
  always_comb begin
    held_char_nxt  = held_char_r;
    held_kind_nxt  = held_kind_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    halt_nxt       = halt_r;
    n_res          = 2'd0;
    r0             = '0;
    r1             = '0;
    br             = '0;
    used           = 1'b0;
    bemit          = 1'b0;

    if (in_acc) begin
      if (in_tlast) begin
        // End of input: finish the held token, clear everything.
        if (!halt_r && held_valid_r) begin
          n_res = 2'd1;
          if (held_kind_r == KIND_NAME || held_kind_r == KIND_INT) begin
            r0 = mk_res(held_kind_r, held_char_r, held_first_r, 1'b1, ERR_NONE);
          end else if (held_char_r == CH_AMP || held_char_r == CH_BAR) begin
            r0 = mk_res(KIND_NAME, held_char_r, 1'b0, 1'b0, ERR_LONE_OP);
          end else if (held_char_r == CH_EQ || held_char_r == CH_BANG) begin
            r0 = mk_res(KIND_NAME, held_char_r, 1'b0, 1'b0, ERR_END_OP);
          end else begin
            r0 = mk_res(KIND_REL, held_char_r, 1'b1, 1'b1, ERR_NONE);
          end
        end
        held_char_nxt  = '0;
        held_kind_nxt  = KIND_NAME;
        held_valid_nxt = 1'b0;
        held_first_nxt = 1'b0;
        halt_nxt       = 1'b0;
      end else if (!halt_r) begin
        if (held_valid_r) begin
          n_res          = 2'd1;
          held_char_nxt  = '0;
          held_kind_nxt  = KIND_NAME;
          held_valid_nxt = 1'b0;
          held_first_nxt = 1'b0;
          if (held_kind_r == KIND_NAME || held_kind_r == KIND_INT) begin
            if ((held_kind_r == KIND_NAME && (is_alpha(c) || is_digit(c))) ||
                (held_kind_r == KIND_INT && is_digit(c))) begin
              // Token continues: release the held char, hold this one.
              r0 = mk_res(held_kind_r, held_char_r, held_first_r, 1'b0, ERR_NONE);
              held_char_nxt  = c;
              held_kind_nxt  = held_kind_r;
              held_valid_nxt = 1'b1;
              used           = 1'b1;
            end else begin
              r0 = mk_res(held_kind_r, held_char_r, held_first_r, 1'b1, ERR_NONE);
            end
          end else if (held_char_r == CH_AMP || held_char_r == CH_BAR) begin
            used = 1'b1;
            if (c != held_char_r) begin
              // lone & or |: follower is consumed with the error
              r0       = mk_res(KIND_NAME, held_char_r, 1'b0, 1'b0, ERR_LONE_OP);
              halt_nxt = 1'b1;
            end else begin
              n_res = 2'd2;
              r0    = mk_res(KIND_COND, held_char_r, 1'b1, 1'b0, ERR_NONE);
              r1    = mk_res(KIND_COND, c, 1'b0, 1'b1, ERR_NONE);
            end
          end else if (c == CH_EQ) begin
            // ==, !=, <=, >= are all relational
            n_res = 2'd2;
            used  = 1'b1;
            r0    = mk_res(KIND_REL, held_char_r, 1'b1, 1'b0, ERR_NONE);
            r1    = mk_res(KIND_REL, c, 1'b0, 1'b1, ERR_NONE);
          end else begin
            r0 = mk_res(held_kind_r, held_char_r, 1'b1, 1'b1, ERR_NONE);
          end
        end

        if (!used && !halt_nxt) begin
          if (is_space(c)) begin
            bemit = 1'b0;
          end else if (is_alpha(c) || is_digit(c)) begin
            held_char_nxt  = c;
            held_kind_nxt  = is_alpha(c) ? KIND_NAME : KIND_INT;
            held_valid_nxt = 1'b1;
            held_first_nxt = 1'b1;
          end else begin
            unique case (c) inside
              CH_LPAREN: begin bemit = 1'b1; br = mk_res(KIND_LPAREN, c, 1'b1, 1'b1, ERR_NONE); end
              CH_RPAREN: begin bemit = 1'b1; br = mk_res(KIND_RPAREN, c, 1'b1, 1'b1, ERR_NONE); end
              CH_LBRACE: begin bemit = 1'b1; br = mk_res(KIND_LBRACE, c, 1'b1, 1'b1, ERR_NONE); end
              CH_RBRACE: begin bemit = 1'b1; br = mk_res(KIND_RBRACE, c, 1'b1, 1'b1, ERR_NONE); end
              CH_SEMI:   begin bemit = 1'b1; br = mk_res(KIND_SEMI, c, 1'b1, 1'b1, ERR_NONE); end
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
                bemit = 1'b1;
                br    = mk_res(KIND_ARITH, c, 1'b1, 1'b1, ERR_NONE);
              end
              CH_EQ, CH_BANG, CH_AMP, CH_BAR, CH_LT, CH_GT: begin
                held_char_nxt  = c;
                held_valid_nxt = 1'b1;
                held_first_nxt = 1'b1;
                if (c == CH_EQ) begin
                  held_kind_nxt = KIND_ASSIGN;
                end else if (c == CH_LT || c == CH_GT) begin
                  held_kind_nxt = KIND_REL;
                end else begin
                  held_kind_nxt = KIND_COND;
                end
              end
              default: begin
                bemit    = 1'b1;
                br       = mk_res(KIND_NAME, c, 1'b0, 1'b0, ERR_UNEXPECTED);
                halt_nxt = 1'b1;
              end
            endcase
          end
          if (bemit) begin
            if (n_res == 2'd0) begin
              r0 = br;
            end else begin
              r1 = br;
            end
            n_res = n_res + 2'd1;
          end
        end
      end
    end

    // Mark the last word caused by this byte.
    if (n_res == 2'd1) begin
      r0.run_last = 1'b1;
    end else if (n_res == 2'd2) begin
      r1.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_kind_r  <= KIND_NAME;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
      halt_r       <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      held_char_r  <= held_char_nxt;
      held_kind_r  <= held_kind_nxt;
      held_valid_r <= held_valid_nxt;
      held_first_r <= held_first_nxt;
      halt_r       <= halt_nxt;
      wr_ptr_r     <= wr_ptr_r + PTR_W'(n_res);
      rd_ptr_r     <= rd_ptr_r + PTR_W'(out_acc);
      cnt_r        <= cnt_r + CNT_W'(n_res) - CNT_W'(out_acc);
    end
  end

  // Queue storage, no reset needed.
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      q_mem[wr_ptr_r] <= r0;
    end
    if (n_res == 2'd2) begin
      q_mem[wr_ptr_r + PTR_W'(1)] <= r1;
    end
  end

  res_t head;
  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {4'b0, head.err, head.last, head.first, head.ch};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.run_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_halt_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !held_valid_r)
    else $error("character held while halted on error");

  a_cont_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (held_valid_r && !held_first_r) |->
      (held_kind_r == KIND_NAME || held_kind_r == KIND_INT))
    else $error("continuation held for an operator token");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && in_acc && !in_tlast) |=> (cnt_r <= $past(cnt_r)))
    else $error("result produced while halted");

endmodule

`default_nettype wire

// File: verif/simple_language_lexer_tb.sv
// simple_language_lexer_tb: self-checking bench for the one-character-lookahead lexer.
// Depends on sll_pkg and simple_language_lexer. A scoreboard class predicts the token
// words; plain tasks drive directed, then random source text with stalls on both sides.
`default_nettype none

module simple_language_lexer_tb;
  import sll_pkg::*;

  localparam int IDLE_PCT     = 12;
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES  = 10;
  localparam int RANDOM_WORDS = 950;

  // One expected token word.
  typedef struct {
    kind_t      kind;
    logic [7:0] ch;
    logic       first;
    logic       last;
    err_t       err;
    logic       run_last;
  } token_word_t;

  // Scoreboard: keeps its own lexer state and the queue of token words still due.
  class token_board;
    logic [7:0]  held_ch;
    kind_t       held_kind;
    logic        held_on;
    logic        held_first;
    logic        halted;
    token_word_t step_words[$];
    token_word_t expected_words[$];
    int          fails;

    function new();
      drop_held();
      halted = 1'b0;
      fails  = 0;
    endfunction

    function logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function void emit(kind_t k, logic [7:0] c, logic f, logic l, err_t e);
      token_word_t w;
      w = '{k, c, f, l, e, 1'b0};
      step_words.insert(step_words.size(), w);
    endfunction

    function void hold(logic [7:0] c, kind_t k, logic f);
      held_ch    = c;
      held_kind  = k;
      held_on    = 1'b1;
      held_first = f;
    endfunction

    function void drop_held();
      held_ch    = 8'h00;
      held_kind  = KIND_NAME;
      held_on    = 1'b0;
      held_first = 1'b0;
    endfunction

    // error word: held char discarded, lexer halts until end marker
    function void fault(logic [7:0] c, err_t e);
      drop_held();
      halted = 1'b1;
      emit(KIND_NAME, c, 1'b0, 1'b0, e);
    endfunction

    // byte with nothing held
    function void start_token(logic [7:0] c);
      if (is_blank(c)) return;
      if (is_letter(c)) begin
        hold(c, KIND_NAME, 1'b1);
      end else if (is_numeral(c)) begin
        hold(c, KIND_INT, 1'b1);
      end else begin
        case (c)
          CH_LPAREN: emit(KIND_LPAREN, c, 1'b1, 1'b1, ERR_NONE);
          CH_RPAREN: emit(KIND_RPAREN, c, 1'b1, 1'b1, ERR_NONE);
          CH_LBRACE: emit(KIND_LBRACE, c, 1'b1, 1'b1, ERR_NONE);
          CH_RBRACE: emit(KIND_RBRACE, c, 1'b1, 1'b1, ERR_NONE);
          CH_SEMI:   emit(KIND_SEMI, c, 1'b1, 1'b1, ERR_NONE);
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT:
            emit(KIND_ARITH, c, 1'b1, 1'b1, ERR_NONE);
          CH_EQ:                  hold(c, KIND_ASSIGN, 1'b1);
          CH_BANG, CH_AMP, CH_BAR: hold(c, KIND_COND, 1'b1);
          CH_LT, CH_GT:           hold(c, KIND_REL, 1'b1);
          default:                fault(c, ERR_UNEXPECTED);
        endcase
      end
    endfunction

    // settle the held char against the next byte; returns 1 if the byte was consumed
    function logic settle(logic [7:0] c);
      logic more;
      if (held_kind == KIND_NAME || held_kind == KIND_INT) begin
        more = (held_kind == KIND_NAME) ? (is_letter(c) || is_numeral(c)) : is_numeral(c);
        if (more) begin
          emit(held_kind, held_ch, held_first, 1'b0, ERR_NONE);
          hold(c, held_kind, 1'b0);
          return 1'b1;
        end
        emit(held_kind, held_ch, held_first, 1'b1, ERR_NONE);
        drop_held();
        return 1'b0;
      end
      if (held_ch == CH_AMP || held_ch == CH_BAR) begin
        // a lone & or | swallows the byte after it
        if (c != held_ch) begin
          fault(held_ch, ERR_LONE_OP);
          return 1'b1;
        end
        emit(KIND_COND, held_ch, 1'b1, 1'b0, ERR_NONE);
        emit(KIND_COND, c, 1'b0, 1'b1, ERR_NONE);
        drop_held();
        return 1'b1;
      end
      if (c == CH_EQ) begin
        emit(KIND_REL, held_ch, 1'b1, 1'b0, ERR_NONE);
        emit(KIND_REL, c, 1'b0, 1'b1, ERR_NONE);
        drop_held();
        return 1'b1;
      end
      emit(held_kind, held_ch, 1'b1, 1'b1, ERR_NONE);
      drop_held();
      return 1'b0;
    endfunction

    function void flush_held();
      if (held_kind == KIND_NAME || held_kind == KIND_INT)
        emit(held_kind, held_ch, held_first, 1'b1, ERR_NONE);
      else if (held_ch == CH_AMP || held_ch == CH_BAR)
        emit(KIND_NAME, held_ch, 1'b0, 1'b0, ERR_LONE_OP);
      else if (held_ch == CH_EQ || held_ch == CH_BANG)
        emit(KIND_NAME, held_ch, 1'b0, 1'b0, ERR_END_OP);
      else
        emit(KIND_REL, held_ch, 1'b1, 1'b1, ERR_NONE);
    endfunction

    // an input word was taken: predict what it yields
    function void note_input(logic [7:0] c, logic end_mark);
      logic used;
      step_words.delete();
      if (end_mark) begin
        if (!halted && held_on) flush_held();
        drop_held();
        halted = 1'b0;
      end else if (!halted) begin
        used = 1'b0;
        if (held_on) used = settle(c);
        if (!used && !halted) start_token(c);
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].run_last = 1'b1;
      foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        fails++;
      end
    endfunction

    // a result word was taken: compare with the oldest prediction
    function void check_result(logic [15:0] data, logic [3:0] user, logic tlast);
      token_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with none due: tdata %h tuser %h tlast %b", data, user, tlast);
        fails++;
        return;
      end
      w = expected_words.pop_front();
      check_field("token_kind", w.kind, user);
      check_field("char_out", w.ch, data[7:0]);
      check_field("token_first", w.first, data[8]);
      check_field("token_last", w.last, data[9]);
      check_field("error_code", w.err, data[11:10]);
      check_field("tdata padding", 8'h00, data[15:12]);
      check_field("run_last", w.run_last, tlast);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] byte_value
  logic        in_tlast = 1'b0;    // end_marker
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] char, [8] first, [9] last, [11:10] error
  logic [3:0]  out_tuser;          // [3:0] token_kind
  logic        out_tlast;          // run_last

  token_board  board = new();
  logic [8:0]  source_words[$];    // {end_marker, byte}
  logic        calm = 1'b0;        // no idling on either side while set
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          stall_count = 0;

  simple_language_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- source text builders ----
  task automatic push_byte(input logic [7:0] b);
    source_words.insert(source_words.size(), {1'b0, b});
  endtask

  task automatic push_end(input logic [7:0] b);
    source_words.insert(source_words.size(), {1'b1, b});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
  endfunction

  function automatic logic [7:0] any_alnum();
    int r;
    r = $urandom_range(0, 61);
    return (r < 10) ? 8'(8'h30 + r) : any_letter();
  endfunction

  function automatic logic [7:0] any_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
  endfunction

  // mostly well-formed tokens, some noise and broken operators
  task automatic add_token();
    int pick;
    int n;
    string ops[10];
    logic [7:0] punct[10];
    ops   = '{"=", "==", "!", "!=", "&&", "||", "<", "<=", ">", ">="};
    punct = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI,
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      push_byte(any_letter());
      n = $urandom_range(0, 5);
      repeat (n) push_byte(any_alnum());
    end else if (pick < 45) begin
      n = $urandom_range(1, 4);
      repeat (n) push_byte(8'(8'h30 + $urandom_range(0, 9)));
    end else if (pick < 65) begin
      push_byte(punct[$urandom_range(0, 9)]);
    end else if (pick < 85) begin
      push_text(ops[$urandom_range(0, 9)]);
    end else if (pick < 90) begin
      // random byte, then recover
      push_byte(8'($urandom_range(0, 255)));
      push_end(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      // lone & or |, or = ! cut off by the end marker
      case ($urandom_range(0, 3))
        0: push_byte(CH_AMP);
        1: push_byte(CH_BAR);
        2: push_byte(CH_EQ);
        default: push_byte(CH_BANG);
      endcase
      if ($urandom_range(0, 1)) push_byte(any_alnum());
      push_end(8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      push_end(8'($urandom_range(0, 255)));
    end else begin
      push_byte(any_blank());
    end
    if ($urandom_range(0, 1)) push_byte(any_blank());
  endtask

  // ---- driver ----
  task automatic send_word(input logic [8:0] w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w[7:0];
    in_tlast  <= w[8];
    do @(posedge clk); while (!in_tready);
    board.note_input(w[7:0], w[8]);
  endtask

  initial begin
    int n_directed;
    // directed: names, integers, every punctuation mark, several operators, a lone |,
    // a halted byte, = cut off by the end marker, byte 0 and byte 255
    push_text("a9(){};+0-*/%==!=<>=&&|x");
    push_byte(8'hff);
    push_end(8'hff);
    push_byte(CH_EQ);
    push_end(8'h00);
    push_byte(8'h00);
    push_end(8'h5a);
    n_directed = source_words.size();
    while (source_words.size() < n_directed + RANDOM_WORDS) add_token();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < source_words.size(); i++) begin
      if (i == n_directed + 250) hold_requests++;   // receiver stops, queue fills
      if (i == n_directed + 450) calm = 1'b1;
      if (i == n_directed + 600) calm = 1'b0;
      if (i == n_directed + 700) begin
        // sender pauses until every due word has drained
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (board.expected_words.size() != 0) @(posedge clk);
      end
      send_word(source_words[i]);
    end
    in_tvalid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.fails == 0 && board.expected_words.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // ---- receiver ----
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_left == 0 && hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // ---- watchdog: no handshake on either side for too long ----
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

endmodule

`default_nettype wire
